@@ design/hfm_pkg.sv @@
// shared constants and types for the force to motor current block
`timescale 1ns / 1ps
package hfm_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 34;
	localparam int TRIG_W       = 24;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [CORDIC_W-1:0] TRIG_LIM = 34'sd4194304;

	localparam logic signed [31:0] GRAV_B_ON_B_DEF = 32'sd0;
	localparam logic signed [31:0] GRAV_C_ON_B_DEF = 32'sd0;
	localparam logic signed [31:0] GRAV_C_ON_C_DEF = 32'sd0;

	typedef enum logic [2:0] {
		REG_ANGLE_GAIN_A = 3'd0,
		REG_ANGLE_GAIN_B = 3'd1,
		REG_ANGLE_GAIN_C = 3'd2,
		REG_LENGTH_B     = 3'd3,
		REG_LENGTH_C     = 3'd4,
		REG_AMPS_GAIN_A  = 3'd5,
		REG_AMPS_GAIN_B  = 3'd6,
		REG_AMPS_GAIN_C  = 3'd7
	} cfg_idx_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] atan_turns(input int i);
		logic signed [CORDIC_W-1:0] r;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ design/hfm_sincos.sv @@
// pipelined joint angle and cordic sine/cosine for one axis
`timescale 1ns / 1ps
module hfm_sincos (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [31:0]                count,
	input  logic signed [31:0]                gain,
	output logic                              out_valid,
	output logic signed [hfm_pkg::TRIG_W-1:0] sin_q22,
	output logic signed [hfm_pkg::TRIG_W-1:0] cos_q22
);
	import hfm_pkg::*;

	logic signed [63:0] angle_prod;
	logic [31:0]        ph_s1;
	logic               v_s1;

	logic                       v_s   [0:CORDIC_STEPS];
	logic                       neg_s [0:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] x_s   [0:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_s   [0:CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_s   [0:CORDIC_STEPS];

	logic        fold;
	logic [31:0] ph_fold;
	logic signed [CORDIC_W-1:0] xr, yr, xc, yc;

	// product modulo one turn (2^40), top 32 bits kept as phase
	assign angle_prod = count * gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= angle_prod[39:8];
	end

	// fold the back half turn onto the front half
	assign fold    = ph_s1[31] ^ ph_s1[30];
	assign ph_fold = fold ? (ph_s1 + 32'h8000_0000) : ph_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0] <= fold;
		x_s[0]   <= CORDIC_K;
		y_s[0]   <= '0;
		z_s[0]   <= CORDIC_W'($signed(ph_fold));
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][CORDIC_W-1]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - atan_turns(i);
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + atan_turns(i);
			end
		end
	end

	// round q3.30 to q1.22 and clamp
	assign xr = (x_s[CORDIC_STEPS] + CORDIC_W'(128)) >>> 8;
	assign yr = (y_s[CORDIC_STEPS] + CORDIC_W'(128)) >>> 8;
	assign xc = (xr > TRIG_LIM) ? TRIG_LIM : ((xr < -TRIG_LIM) ? -TRIG_LIM : xr);
	assign yc = (yr > TRIG_LIM) ? TRIG_LIM : ((yr < -TRIG_LIM) ? -TRIG_LIM : yr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		sin_q22 <= neg_s[CORDIC_STEPS] ? -yc[TRIG_W-1:0] : yc[TRIG_W-1:0];
		cos_q22 <= neg_s[CORDIC_STEPS] ? -xc[TRIG_W-1:0] : xc[TRIG_W-1:0];
	end

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sin_q22 <= TRIG_W'(4194304)) && (sin_q22 >= -TRIG_W'(4194304)))
		else $error("sine out of range");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cos_q22 <= TRIG_W'(4194304)) && (cos_q22 >= -TRIG_W'(4194304)))
		else $error("cosine out of range");

endmodule

@@ design/haptic_force_to_motor_amps.sv @@
// top level: encoder counts and cartesian force to three motor currents
//
// channel   ports                                     handshake
// input     count_a/b/c, force_x/y/z                  start, busy (always low)
// result    current_a/b/c, clipped                    done, one cycle wide
// config    wr_index, wr_data                         wr_en, no wait
//
// one transaction enters every cycle; a result leaves through the angle, fold,
// 24 cordic and round stages plus the lever, jacobian, force product, torque sum,
// gain product and saturation stages
// arst_n clears only the valid bits and the configuration registers
// nothing stalls: busy stays low and the receiver takes every done
`timescale 1ns / 1ps
module haptic_force_to_motor_amps #(
	parameter logic signed [31:0] GRAV_B_ON_B = hfm_pkg::GRAV_B_ON_B_DEF,
	parameter logic signed [31:0] GRAV_C_ON_B = hfm_pkg::GRAV_C_ON_B_DEF,
	parameter logic signed [31:0] GRAV_C_ON_C = hfm_pkg::GRAV_C_ON_C_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] count_a,
	input  logic signed [31:0] count_b,
	input  logic signed [31:0] count_c,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	output logic               done,
	output logic signed [31:0] current_a,
	output logic signed [31:0] current_b,
	output logic signed [31:0] current_c,
	output logic               clipped
);
	import hfm_pkg::*;

	localparam int FDLY = CORDIC_STEPS + 3;

	logic signed [31:0] angle_gain_a_q, angle_gain_b_q, angle_gain_c_q;
	logic [15:0]        length_b_q, length_c_q;
	logic signed [31:0] amps_gain_a_q, amps_gain_b_q, amps_gain_c_q;

	logic accept;
	logic va, vb, vc;
	logic signed [TRIG_W-1:0] sa, ca, sb, cb, sc, cc;

	// force delay line matching the angle pipeline
	logic signed [31:0] fx_d [0:FDLY-1];
	logic signed [31:0] fy_d [0:FDLY-1];
	logic signed [31:0] fz_d [0:FDLY-1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_gain_a_q <= '0;
			angle_gain_b_q <= '0;
			angle_gain_c_q <= '0;
			length_b_q     <= '0;
			length_c_q     <= '0;
			amps_gain_a_q  <= '0;
			amps_gain_b_q  <= '0;
			amps_gain_c_q  <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_ANGLE_GAIN_A: angle_gain_a_q <= wr_data;
				REG_ANGLE_GAIN_B: angle_gain_b_q <= wr_data;
				REG_ANGLE_GAIN_C: angle_gain_c_q <= wr_data;
				REG_LENGTH_B:     length_b_q     <= wr_data[15:0];
				REG_LENGTH_C:     length_c_q     <= wr_data[15:0];
				REG_AMPS_GAIN_A:  amps_gain_a_q  <= wr_data;
				REG_AMPS_GAIN_B:  amps_gain_b_q  <= wr_data;
				REG_AMPS_GAIN_C:  amps_gain_c_q  <= wr_data;
				default: ;
			endcase
		end
	end

	hfm_sincos u_sc_a (.clk, .arst_n, .in_valid(accept), .count(count_a),
		.gain(angle_gain_a_q), .out_valid(va), .sin_q22(sa), .cos_q22(ca));
	hfm_sincos u_sc_b (.clk, .arst_n, .in_valid(accept), .count(count_b),
		.gain(angle_gain_b_q), .out_valid(vb), .sin_q22(sb), .cos_q22(cb));
	hfm_sincos u_sc_c (.clk, .arst_n, .in_valid(accept), .count(count_c),
		.gain(angle_gain_c_q), .out_valid(vc), .sin_q22(sc), .cos_q22(cc));

	always_ff @(posedge clk) begin
		fx_d[0] <= force_x;
		fy_d[0] <= force_y;
		fz_d[0] <= force_z;
		for (int i = 1; i < FDLY; i++) begin
			fx_d[i] <= fx_d[i-1];
			fy_d[i] <= fy_d[i-1];
			fz_d[i] <= fz_d[i-1];
		end
	end

	// stage 1: lever arms
	logic signed [40:0] p_lbsb, p_lbcb, p_lcsc, p_lccc;
	logic signed [41:0] p_r;
	logic signed [41:0] r_full;
	logic signed [40:0] lbsb_f, lbcb_f, lcsc_f, lccc_f;
	logic               v_s1;
	logic signed [25:0] r_s1;
	logic signed [24:0] lbsb_s1, lbcb_s1, lcsc_s1, lccc_s1;
	logic signed [TRIG_W-1:0] sa_s1, ca_s1, sb_s1, sc_s1;
	logic signed [31:0] fx_s1, fy_s1, fz_s1;

	assign p_lbsb = $signed({1'b0, length_b_q}) * sb;
	assign p_lbcb = $signed({1'b0, length_b_q}) * cb;
	assign p_lcsc = $signed({1'b0, length_c_q}) * sc;
	assign p_lccc = $signed({1'b0, length_c_q}) * cc;
	assign p_r    = p_lbsb + p_lcsc;
	assign r_full = (p_r + 42'sd32768) >>> 16;
	assign lbsb_f = (p_lbsb + 41'sd32768) >>> 16;
	assign lbcb_f = (p_lbcb + 41'sd32768) >>> 16;
	assign lcsc_f = (p_lcsc + 41'sd32768) >>> 16;
	assign lccc_f = (p_lccc + 41'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= va && vb && vc;
		end
	end

	always_ff @(posedge clk) begin
		r_s1    <= r_full[25:0];
		lbsb_s1 <= lbsb_f[24:0];
		lbcb_s1 <= lbcb_f[24:0];
		lcsc_s1 <= lcsc_f[24:0];
		lccc_s1 <= lccc_f[24:0];
		sa_s1   <= sa;
		ca_s1   <= ca;
		sb_s1   <= sb;
		sc_s1   <= sc;
		fx_s1   <= fx_d[FDLY-1];
		fy_s1   <= fy_d[FDLY-1];
		fz_s1   <= fz_d[FDLY-1];
	end

	// stage 2: jacobian entries
	logic signed [49:0] p_rs, p_rc, p_bc, p_bs, p_cc, p_cs;
	logic signed [49:0] j0_f, j1_f, j2_f, j3_f, j4_f, j5_f;
	logic               v_s2;
	logic signed [25:0] j0_s2, j1_s2, j2_s2, j3_s2, j4_s2, j5_s2;
	logic signed [24:0] lbsb_s2, lcsc_s2;
	logic signed [TRIG_W-1:0] sb_s2, sc_s2;
	logic signed [31:0] fx_s2, fy_s2, fz_s2;

	assign p_rs = r_s1 * sa_s1;
	assign p_rc = r_s1 * ca_s1;
	assign p_bc = lbcb_s1 * ca_s1;
	assign p_bs = lbcb_s1 * sa_s1;
	assign p_cc = lccc_s1 * ca_s1;
	assign p_cs = lccc_s1 * sa_s1;
	assign j0_f = (-p_rs + 50'sd2097152) >>> 22;
	assign j1_f = (p_rc + 50'sd2097152) >>> 22;
	assign j2_f = (p_bc + 50'sd2097152) >>> 22;
	assign j3_f = (p_bs + 50'sd2097152) >>> 22;
	assign j4_f = (p_cc + 50'sd2097152) >>> 22;
	assign j5_f = (p_cs + 50'sd2097152) >>> 22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		j0_s2   <= j0_f[25:0];
		j1_s2   <= j1_f[25:0];
		j2_s2   <= j2_f[25:0];
		j3_s2   <= j3_f[25:0];
		j4_s2   <= j4_f[25:0];
		j5_s2   <= j5_f[25:0];
		lbsb_s2 <= lbsb_s1;
		lcsc_s2 <= lcsc_s1;
		sb_s2   <= sb_s1;
		sc_s2   <= sc_s1;
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
		fz_s2   <= fz_s1;
	end

	// stage 3: force and gravity products in q.38
	logic               v_s3;
	logic signed [57:0] px0_s3, px1_s3;
	logic signed [57:0] py0_s3, py1_s3, py2_s3, py3_s3, py4_s3;
	logic signed [57:0] pz0_s3, pz1_s3, pz2_s3, pz3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px0_s3 <= 58'(j0_s2 * fx_s2);
		px1_s3 <= 58'(j1_s2 * fy_s2);
		py0_s3 <= 58'(j2_s2 * fx_s2);
		py1_s3 <= 58'(j3_s2 * fy_s2);
		py2_s3 <= -58'(lbsb_s2 * fz_s2);
		py3_s3 <= 58'(GRAV_B_ON_B * sb_s2);
		py4_s3 <= 58'(GRAV_C_ON_B * sc_s2);
		pz0_s3 <= 58'(j4_s2 * fx_s2);
		pz1_s3 <= 58'(j5_s2 * fy_s2);
		pz2_s3 <= 58'(lcsc_s2 * fz_s2);
		pz3_s3 <= 58'(GRAV_C_ON_C * sc_s2);
	end

	// stage 4: torque sums rounded to q23.16
	logic signed [61:0] tx_f, ty_f, tz_f;
	logic               v_s4;
	logic signed [39:0] tx_s4, ty_s4, tz_s4;

	assign tx_f = (62'(px0_s3) + 62'(px1_s3) + 62'sd2097152) >>> 22;
	assign ty_f = (62'(py0_s3) + 62'(py1_s3) + 62'(py2_s3) + 62'(py3_s3) + 62'(py4_s3)
		+ 62'sd2097152) >>> 22;
	assign tz_f = (62'(pz0_s3) + 62'(pz1_s3) + 62'(pz2_s3) + 62'(pz3_s3)
		+ 62'sd2097152) >>> 22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tx_s4 <= tx_f[39:0];
		ty_s4 <= ty_f[39:0];
		tz_s4 <= tz_f[39:0];
	end

	// stage 5: amps gain split into integer and fraction halves
	logic signed [56:0] lo_a, lo_b, lo_c;
	logic signed [56:0] lr_a, lr_b, lr_c;
	logic               v_s5;
	logic signed [55:0] hi_a_s5, hi_b_s5, hi_c_s5;
	logic signed [40:0] lo_a_s5, lo_b_s5, lo_c_s5;

	assign lo_a = tx_s4 * $signed({1'b0, amps_gain_a_q[15:0]});
	assign lo_b = ty_s4 * $signed({1'b0, amps_gain_b_q[15:0]});
	assign lo_c = tz_s4 * $signed({1'b0, amps_gain_c_q[15:0]});
	assign lr_a = (lo_a + 57'sd32768) >>> 16;
	assign lr_b = (lo_b + 57'sd32768) >>> 16;
	assign lr_c = (lo_c + 57'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		hi_a_s5 <= tx_s4 * $signed(amps_gain_a_q[31:16]);
		hi_b_s5 <= ty_s4 * $signed(amps_gain_b_q[31:16]);
		hi_c_s5 <= tz_s4 * $signed(amps_gain_c_q[31:16]);
		lo_a_s5 <= lr_a[40:0];
		lo_b_s5 <= lr_b[40:0];
		lo_c_s5 <= lr_c[40:0];
	end

	// stage 6: sum and saturate
	localparam logic signed [56:0] I32_MAX = 57'sd2147483647;
	localparam logic signed [56:0] I32_MIN = -57'sd2147483648;
	logic signed [56:0] sum_a, sum_b, sum_c;
	logic hi_a, lo_a_c, hi_b, lo_b_c, hi_c, lo_c_c;

	assign sum_a  = 57'(hi_a_s5) + 57'(lo_a_s5);
	assign sum_b  = 57'(hi_b_s5) + 57'(lo_b_s5);
	assign sum_c  = 57'(hi_c_s5) + 57'(lo_c_s5);
	assign hi_a   = sum_a > I32_MAX;
	assign lo_a_c = sum_a < I32_MIN;
	assign hi_b   = sum_b > I32_MAX;
	assign lo_b_c = sum_b < I32_MIN;
	assign hi_c   = sum_c > I32_MAX;
	assign lo_c_c = sum_c < I32_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		current_a <= hi_a ? 32'sh7fff_ffff : (lo_a_c ? 32'sh8000_0000 : sum_a[31:0]);
		current_b <= hi_b ? 32'sh7fff_ffff : (lo_b_c ? 32'sh8000_0000 : sum_b[31:0]);
		current_c <= hi_c ? 32'sh7fff_ffff : (lo_c_c ? 32'sh8000_0000 : sum_c[31:0]);
		clipped   <= hi_a || lo_a_c || hi_b || lo_b_c || hi_c || lo_c_c;
	end

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |->
			current_a == 32'sh7fff_ffff || current_a == 32'sh8000_0000 ||
			current_b == 32'sh7fff_ffff || current_b == 32'sh8000_0000 ||
			current_c == 32'sh7fff_ffff || current_c == 32'sh8000_0000)
		else $error("clip flag without a saturated current");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_follows_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |=> done)
		else $error("pipeline result dropped");

endmodule
